// ===== design/arxpmf_pkg.sv =====
package arxpmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int FRAC_W   = 13;
  localparam int DELAY_W  = 4;

  // Coefficient registers that exist on the configuration port
  localparam int NUM_CFG_A = 3;
  localparam int NUM_CFG_B = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_A_COEF_1       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COEF_2       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COEF_3       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COEF_0       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COEF_1       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COEF_2       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPORT_DELAY = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef struct packed {
    sample_t plant_input;
    sample_t disturbance;
  } in_item_t;

  typedef struct packed {
    sample_t noisy_output;
    sample_t clean_output;
    logic    saturated;
  } out_item_t;

  // Per-cell control of the dead-time line
  typedef struct packed {
    logic shift;
    logic load;
  } dt_ctrl_t;

endpackage

// ===== design/arxpmf_dt_cell.sv =====
module arxpmf_dt_cell
  import arxpmf_pkg::*;
(
  input  logic     clk_i,
  input  dt_ctrl_t ctrl_i,
  input  sample_t  next_i,
  input  sample_t  sample_i,
  output sample_t  q_o
);

  sample_t data_q;

  // load takes the new sample at the tail, shift pulls from the next cell
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= sample_i;
    end else if (ctrl_i.shift) begin
      data_q <= next_i;
    end
  end

  assign q_o = data_q;

endmodule

// ===== design/arxpmf_tap_cell.sv =====
module arxpmf_tap_cell
  import arxpmf_pkg::*;
#(
  parameter bit USE_NEXT = 1'b0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  sample_t din_i,
  input  coef_t   coef_i,
  output sample_t q_o,
  output prod_t   prod_o
);

  sample_t data_q;
  sample_t data_d;
  sample_t operand;

  assign data_d  = en_i ? din_i : data_q;
  // input taps weigh the freshly shifted sample, output taps the stored one
  assign operand = USE_NEXT ? data_d : data_q;
  assign prod_o  = coef_i * operand;
  assign q_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

endmodule

// ===== design/arx_plant_model_filter.sv =====
// ARX plant model with dead time, Q2.13.
// Results are registered in the output register, or in the skid register on a stall.
// Throughput: one request per cycle while in_stall_o is low; the output feedback
// through six multipliers, the adder tree and the saturation closes within that cycle.
// A two-entry output buffer takes one more request during an output stall.
// Reset (asynchronous, active low) clears coefficients, delay, fill count and histories.
module arx_plant_model_filter
  import arxpmf_pkg::*;
#(
  parameter int NUM_A_TAPS    = 3,
  parameter int NUM_B_TAPS    = 3,
  parameter int MAX_DEAD_TIME = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int FILL_W = $clog2(MAX_DEAD_TIME + 1);
  localparam int CMP_W  = (FILL_W > DELAY_W) ? FILL_W : DELAY_W;
  localparam int ACC_W  = PROD_W + $clog2(NUM_A_TAPS + NUM_B_TAPS) + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(2 ** (FRAC_W - 1));

  // configuration
  coef_t              a_coef_q [NUM_CFG_A];
  coef_t              b_coef_q [NUM_CFG_B];
  logic [DELAY_W-1:0] delay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG_A; i++) a_coef_q[i] <= '0;
      for (int i = 0; i < NUM_CFG_B; i++) b_coef_q[i] <= '0;
      delay_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_A_COEF_1:        a_coef_q[0] <= cfg_data_i;
        CFG_A_COEF_2:        a_coef_q[1] <= cfg_data_i;
        CFG_A_COEF_3:        a_coef_q[2] <= cfg_data_i;
        CFG_B_COEF_0:        b_coef_q[0] <= cfg_data_i;
        CFG_B_COEF_1:        b_coef_q[1] <= cfg_data_i;
        CFG_B_COEF_2:        b_coef_q[2] <= cfg_data_i;
        CFG_TRANSPORT_DELAY: delay_q     <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and output buffer
  logic      accept;
  logic      out_take;
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q, result;

  assign accept      = in_valid_i & ~skid_valid_q;
  assign out_take    = out_valid_q & ~out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  // dead-time line
  logic [FILL_W-1:0] fill_q, fill_d, tail;
  logic [CMP_W-1:0]  delay_ext, max_ext, eff_delay;
  logic              pop, fill_nz;
  sample_t           line [MAX_DEAD_TIME];
  dt_ctrl_t          dt_ctrl [MAX_DEAD_TIME];
  sample_t           x_new;

  assign delay_ext = CMP_W'(delay_q);
  assign max_ext   = CMP_W'(MAX_DEAD_TIME);
  assign eff_delay = (delay_ext > max_ext) ? max_ext : delay_ext;
  assign pop       = CMP_W'(fill_q) >= eff_delay;
  assign fill_nz   = fill_q != '0;
  assign tail      = pop ? fill_q - FILL_W'(1) : fill_q;
  assign fill_d    = (accept && !pop) ? fill_q + FILL_W'(1) : fill_q;
  assign x_new     = fill_nz ? line[0] : in_data_i.plant_input;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  for (genvar k = 0; k < MAX_DEAD_TIME; k++) begin : g_dt
    sample_t next;
    if (k == MAX_DEAD_TIME - 1) begin : g_last
      assign next = in_data_i.plant_input;
    end else begin : g_mid
      assign next = line[k+1];
    end
    // when popping with an empty line the sample bypasses every cell
    assign dt_ctrl[k].load  = accept & (~pop | fill_nz) & (tail == FILL_W'(k));
    assign dt_ctrl[k].shift = accept & pop & fill_nz & (FILL_W'(k) < tail);

    arxpmf_dt_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (dt_ctrl[k]),
      .next_i   (next),
      .sample_i (in_data_i.plant_input),
      .q_o      (line[k])
    );
  end

  // input taps
  sample_t x_hist [NUM_B_TAPS];
  prod_t   b_prod [NUM_B_TAPS];

  for (genvar j = 0; j < NUM_B_TAPS; j++) begin : g_b
    sample_t din;
    coef_t   coef;
    if (j == 0) begin : g_first
      assign din = x_new;
    end else begin : g_rest
      assign din = x_hist[j-1];
    end
    if (j < NUM_CFG_B) begin : g_cfg
      assign coef = b_coef_q[j];
    end else begin : g_zero
      assign coef = '0;
    end

    arxpmf_tap_cell #(.USE_NEXT(1'b1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept & pop),
      .din_i  (din),
      .coef_i (coef),
      .q_o    (x_hist[j]),
      .prod_o (b_prod[j])
    );
  end

  // output taps
  sample_t y_hist [NUM_A_TAPS];
  prod_t   a_prod [NUM_A_TAPS];
  sample_t clean;

  for (genvar i = 0; i < NUM_A_TAPS; i++) begin : g_a
    sample_t din;
    coef_t   coef;
    if (i == 0) begin : g_first
      assign din = clean;
    end else begin : g_rest
      assign din = y_hist[i-1];
    end
    if (i < NUM_CFG_A) begin : g_cfg
      assign coef = a_coef_q[i];
    end else begin : g_zero
      assign coef = '0;
    end

    arxpmf_tap_cell #(.USE_NEXT(1'b0)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .din_i  (din),
      .coef_i (coef),
      .q_o    (y_hist[i]),
      .prod_o (a_prod[i])
    );
  end

  // sum, round half up, saturate
  logic signed [ACC_W-1:0] acc, rounded;
  logic                    clean_hit, noisy_hit;
  logic signed [SAMPLE_W:0] noisy_sum;
  sample_t                 noisy;

  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_A_TAPS; i++) acc = acc - ACC_W'(a_prod[i]);
    for (int j = 0; j < NUM_B_TAPS; j++) acc = acc + ACC_W'(b_prod[j]);
  end

  assign rounded   = (acc + RND) >>> FRAC_W;
  assign clean_hit = (rounded > SAT_HI) || (rounded < SAT_LO);
  assign clean     = (rounded > SAT_HI) ? SAT_HI[SAMPLE_W-1:0] :
                     (rounded < SAT_LO) ? SAT_LO[SAMPLE_W-1:0] :
                     rounded[SAMPLE_W-1:0];

  assign noisy_sum = (SAMPLE_W+1)'(clean) + (SAMPLE_W+1)'(in_data_i.disturbance);
  assign noisy_hit = noisy_sum[SAMPLE_W] != noisy_sum[SAMPLE_W-1];
  // clip toward the sign of the wide sum
  assign noisy     = !noisy_hit ? noisy_sum[SAMPLE_W-1:0] :
                     noisy_sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} :
                                           {1'b0, {(SAMPLE_W-1){1'b1}}};

  assign result.noisy_output = noisy;
  assign result.clean_output = clean;
  assign result.saturated    = clean_hit | noisy_hit;

endmodule

// ===== bench/tb_arx_plant_model_filter.sv =====
module tb_arx_plant_model_filter;
  import arxpmf_pkg::*;

  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  DRAIN_CYCLES = 4;
  localparam int  NUM_PHASES   = 8;
  localparam int  PHASE_ITEMS  = 130;
  localparam int  LINE_DEPTH   = 16;
  localparam int  QUEUE_DEPTH  = 2048;
  localparam longint S_MAX     = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint S_MIN     = -S_MAX - 1;
  localparam longint HALF_LSB  = longint'(1) << (FRAC_W - 1);

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  arx_plant_model_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Plant model state and configuration
  coef_t              a_coef_r [NUM_CFG_A];
  coef_t              b_coef_r [NUM_CFG_B];
  logic [DELAY_W-1:0] dead_time;
  sample_t            dly_line [LINE_DEPTH];
  int                 dly_fill;
  sample_t            u_hist   [NUM_CFG_B];
  sample_t            y_hist   [NUM_CFG_A];

  // Pending requests and expected results, as ring buffers with running counts
  in_item_t  req_mem [QUEUE_DEPTH];
  out_item_t exp_mem [QUEUE_DEPTH];
  int        req_wr = 0;
  int        req_rd = 0;
  int        exp_wr = 0;
  int        exp_rd = 0;
  out_item_t want;

  int errors     = 0;
  int cycles     = 0;
  int in_gap     = 0;
  int stall_left = 0;
  bit idle_on    = 1'b0;
  bit in_fire    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic sample_t sat16(longint v, inout bit hit);
    if (v > S_MAX) begin
      hit = 1'b1;
      return sample_t'(S_MAX);
    end
    if (v < S_MIN) begin
      hit = 1'b1;
      return sample_t'(S_MIN);
    end
    return sample_t'(v);
  endfunction

  function automatic out_item_t arx_step(in_item_t req);
    longint    acc;
    sample_t   delayed;
    sample_t   clean;
    bit        hit;
    int        i;
    out_item_t res;
    acc     = 0;
    hit     = 1'b0;
    delayed = '0;
    if (dly_fill >= int'(dead_time)) begin
      if (dly_fill == 0) begin
        delayed = req.plant_input;
      end else begin
        // pop the oldest, push the new one at the last filled slot
        delayed = dly_line[0];
        for (i = 0; i < dly_fill - 1; i++) dly_line[i] = dly_line[i + 1];
        dly_line[dly_fill - 1] = req.plant_input;
      end
      for (i = NUM_CFG_B - 1; i > 0; i--) u_hist[i] = u_hist[i - 1];
      u_hist[0] = delayed;
    end else begin
      dly_line[dly_fill] = req.plant_input;
      dly_fill++;
    end
    for (i = 0; i < NUM_CFG_A; i++) acc -= longint'(a_coef_r[i]) * longint'(y_hist[i]);
    for (i = 0; i < NUM_CFG_B; i++) acc += longint'(b_coef_r[i]) * longint'(u_hist[i]);
    clean = sat16((acc + HALF_LSB) >>> FRAC_W, hit);
    for (i = NUM_CFG_A - 1; i > 0; i--) y_hist[i] = y_hist[i - 1];
    y_hist[0] = clean;
    res.noisy_output = sat16(longint'(clean) + longint'(req.disturbance), hit);
    res.clean_output = clean;
    res.saturated    = hit;
    return res;
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endfunction

  // Monitor: predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire = in_valid_i && !in_stall_o;
      if (in_fire) begin
        exp_mem[exp_wr % QUEUE_DEPTH] = arx_step(in_data_i);
        exp_wr++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (exp_rd == exp_wr) begin
          errors++;
          $display("%0t: result with none expected, expected nothing, actual %p",
                   $time, out_data_o);
        end else begin
          want = exp_mem[exp_rd % QUEUE_DEPTH];
          exp_rd++;
          check_field("noisy_output", want.noisy_output, out_data_o.noisy_output);
          check_field("clean_output", want.clean_output, out_data_o.clean_output);
          check_field("saturated", want.saturated, out_data_o.saturated);
        end
      end
    end
  end

  // Driver for requests and output stall
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (req_rd == req_wr) begin
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        in_gap = $urandom_range(0, 10);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= req_mem[req_rd % QUEUE_DEPTH];
        req_rd++;
      end
    end
    if (!idle_on) stall_left = 0;
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_A_COEF_1:        a_coef_r[0] = coef_t'(val);
      CFG_A_COEF_2:        a_coef_r[1] = coef_t'(val);
      CFG_A_COEF_3:        a_coef_r[2] = coef_t'(val);
      CFG_B_COEF_0:        b_coef_r[0] = coef_t'(val);
      CFG_B_COEF_1:        b_coef_r[1] = coef_t'(val);
      CFG_B_COEF_2:        b_coef_r[2] = coef_t'(val);
      CFG_TRANSPORT_DELAY: dead_time   = val[DELAY_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_config(coef_t a1, coef_t a2, coef_t a3,
                              coef_t b0, coef_t b1, coef_t b2, int dly);
    cfg_write(CFG_A_COEF_1, a1);
    cfg_write(CFG_A_COEF_2, a2);
    cfg_write(CFG_A_COEF_3, a3);
    cfg_write(CFG_B_COEF_0, b0);
    cfg_write(CFG_B_COEF_1, b1);
    cfg_write(CFG_B_COEF_2, b2);
    cfg_write(CFG_TRANSPORT_DELAY, CFG_DATA_W'(dly));
  endtask

  // Hold until every request went out and every result came back
  task automatic drain();
    while (req_rd != req_wr || in_valid_i || exp_rd != exp_wr)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_req(int u, int d);
    in_item_t r;
    r.plant_input = sample_t'(u);
    r.disturbance = sample_t'(d);
    req_mem[req_wr % QUEUE_DEPTH] = r;
    req_wr++;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0:       return 32767;
      1:       return -32768;
      2, 3:    return int'($urandom_range(0, 1023)) - 512;
      default: return int'(sample_t'($urandom_range(0, 65535)));
    endcase
  endfunction

  function automatic coef_t rand_coef(bit gentle);
    if (gentle) return coef_t'(int'($urandom_range(0, 4095)) - 2048);
    case ($urandom_range(0, 5))
      0:       return coef_t'(16'h7FFF);
      1:       return coef_t'(16'h8000);
      2:       return coef_t'(0);
      3:       return coef_t'(16'h2000);
      default: return coef_t'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int p;
    int n;
    int dly;
    bit gentle;
    foreach (a_coef_r[i]) a_coef_r[i] = '0;
    foreach (b_coef_r[i]) b_coef_r[i] = '0;
    foreach (dly_line[i]) dly_line[i] = '0;
    foreach (u_hist[i]) u_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;
    dead_time = '0;
    dly_fill  = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset coefficients: output is the disturbance alone
    idle_on = 1'b1;
    add_req(32767, 32767);
    add_req(-32768, -32768);
    add_req(0, 32767);
    add_req(-1, -32768);
    drain();

    // Extreme coefficients, zero delay: saturation on both outputs
    apply_config(coef_t'(16'h8000), coef_t'(16'h7FFF), coef_t'(16'h1000),
                 coef_t'(16'h2000), coef_t'(16'h7FFF), coef_t'(16'h8000), 0);
    add_req(32767, 0);
    add_req(-32768, 32767);
    add_req(0, -32768);
    add_req(1, -1);
    add_req(-1, 1);
    add_req(16384, 0);
    add_req(-16384, 0);
    drain();

    // Unity pass-through with dead time, then lower the delay with the line filled
    apply_config(coef_t'(0), coef_t'(0), coef_t'(0),
                 coef_t'(16'h2000), coef_t'(0), coef_t'(0), 3);
    for (n = 1; n <= 6; n++) add_req(n * 1000, 0);
    drain();
    cfg_write(CFG_TRANSPORT_DELAY, CFG_DATA_W'(1));
    for (n = 1; n <= 4; n++) add_req(-n * 700, n);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1)      dly = 0;
      else if (p == NUM_PHASES - 2) dly = 15;
      else                          dly = $urandom_range(0, 2 * p + 1);
      gentle = (p % 2 == 0);
      apply_config(rand_coef(gentle), rand_coef(gentle), rand_coef(gentle),
                   rand_coef(1'b0), rand_coef(gentle), rand_coef(gentle), dly);
      idle_on = (p == 0) || (p < NUM_PHASES - 1 && $urandom_range(0, 3) != 0);
      for (n = 0; n < PHASE_ITEMS; n++) add_req(rand_sample(), rand_sample());
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/arxpmf_pkg.sv
design/arxpmf_dt_cell.sv
design/arxpmf_tap_cell.sv
design/arx_plant_model_filter.sv
bench/tb_arx_plant_model_filter.sv
